// File: rtl/core/rtab_pkg.sv
// Package for the RGBA tint / alpha blend unit: widths, register indexes,
// blend modes, pipeline control struct and the widening helper.
// No dependencies.
package rtab_pkg;

   localparam int CHAN_W       = 8;                    // one color channel
   localparam int WIDE_W       = CHAN_W + 1;           // widened channel, 0..256
   localparam int WEIGHT_SHIFT = 2 * CHAN_W;           // fixed point scale of weight
   localparam int WEIGHT_W     = WEIGHT_SHIFT + 1;     // weight 0..65536
   localparam int DIFF_W       = CHAN_W + 2;           // signed target - dst
   localparam int PROD_W       = DIFF_W + WEIGHT_W + 1;
   localparam int SCALE_W      = WIDE_W + CHAN_W;      // widened tint * source
   localparam int NUM_LANES    = 4;
   localparam int NUM_STAGES   = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = CHAN_W;

   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT_RED   = 3'd0,
      CSR_TINT_GREEN = 3'd1,
      CSR_TINT_BLUE  = 3'd2,
      CSR_TINT_ALPHA = 3'd3,
      CSR_BLEND_MODE = 3'd4
   } csr_index_type;

   typedef enum logic {
      MODE_TINT  = 1'b0,
      MODE_SOLID = 1'b1
   } blend_mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0] tint_red;
      logic [CHAN_W-1:0] tint_green;
      logic [CHAN_W-1:0] tint_blue;
      logic [CHAN_W-1:0] tint_alpha;
      blend_mode_type    blend_mode;
   } cfg_type;

   // Load enables for the three pipeline stages.
   typedef struct packed {
      logic load_in;
      logic load_mul;
      logic load_out;
   } stage_ctrl_type;

   // v -> v + 1 when nonzero, else 0
   function automatic logic [WIDE_W-1:0] widen(input logic [CHAN_W-1:0] v);
      logic [WIDE_W-1:0] w;
      w = {1'b0, v} + WIDE_W'(v != '0);
      return w;
   endfunction

endpackage

// File: rtl/core/rtab_if.sv
// Channel interfaces of the blend unit: pixel request, blended response and
// register write port. Depends on rtab_pkg.
interface rtab_req_if;
   logic                      valid;
   logic                      ready;
   logic [rtab_pkg::CHAN_W-1:0] src_red;
   logic [rtab_pkg::CHAN_W-1:0] src_green;
   logic [rtab_pkg::CHAN_W-1:0] src_blue;
   logic [rtab_pkg::CHAN_W-1:0] src_alpha;
   logic [rtab_pkg::CHAN_W-1:0] dst_red;
   logic [rtab_pkg::CHAN_W-1:0] dst_green;
   logic [rtab_pkg::CHAN_W-1:0] dst_blue;
   logic [rtab_pkg::CHAN_W-1:0] dst_alpha;

   modport source (output valid, src_red, src_green, src_blue, src_alpha,
                   dst_red, dst_green, dst_blue, dst_alpha, input ready);
   modport sink   (input valid, src_red, src_green, src_blue, src_alpha,
                   dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface rtab_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rtab_pkg::CHAN_W-1:0] out_red;
   logic [rtab_pkg::CHAN_W-1:0] out_green;
   logic [rtab_pkg::CHAN_W-1:0] out_blue;
   logic [rtab_pkg::CHAN_W-1:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                   output ready);
endinterface

interface rtab_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rtab_pkg::CSR_IDX_W-1:0]  index;
   logic [rtab_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rtab_csr.sv
// Configuration registers of the blend unit (tint color and blend mode).
// Depends on rtab_pkg and rtab_if.
module rtab_csr (
   input  logic              clock,
   input  logic              reset,
   rtab_csr_if.sink          csr_bus,
   output rtab_pkg::cfg_type cfg
);

   rtab_pkg::cfg_type cfg_ff;
   rtab_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (rtab_pkg::csr_index_type'(csr_bus.index))
            rtab_pkg::CSR_TINT_RED:   cfg_in.tint_red   = csr_bus.data;
            rtab_pkg::CSR_TINT_GREEN: cfg_in.tint_green = csr_bus.data;
            rtab_pkg::CSR_TINT_BLUE:  cfg_in.tint_blue  = csr_bus.data;
            rtab_pkg::CSR_TINT_ALPHA: cfg_in.tint_alpha = csr_bus.data;
            rtab_pkg::CSR_BLEND_MODE:
               cfg_in.blend_mode = rtab_pkg::blend_mode_type'(csr_bus.data[0]);
            default: ;   // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_red   <= rtab_pkg::CHAN_MAX;
         cfg_ff.tint_green <= rtab_pkg::CHAN_MAX;
         cfg_ff.tint_blue  <= rtab_pkg::CHAN_MAX;
         cfg_ff.tint_alpha <= rtab_pkg::CHAN_MAX;
         cfg_ff.blend_mode <= rtab_pkg::MODE_TINT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/rtab_ctrl.sv
// Valid/ready control of the three-stage blend pipeline; each stage fills
// when it is empty or its successor moves. Depends on rtab_pkg.
module rtab_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rtab_pkg::stage_ctrl_type stage_ctrl
);

   logic [rtab_pkg::NUM_STAGES-1:0] valid_ff;
   logic [rtab_pkg::NUM_STAGES-1:0] valid_in;
   logic [rtab_pkg::NUM_STAGES-1:0] move;

   always_comb begin
      move[2] = !valid_ff[2] || out_ready;
      move[1] = !valid_ff[1] || move[2];
      move[0] = !valid_ff[0] || move[1];
      valid_in[0] = move[0] ? in_valid    : valid_ff[0];
      valid_in[1] = move[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = move[2] ? valid_ff[1] : valid_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready            = move[0];
   assign out_valid           = valid_ff[2];
   assign stage_ctrl.load_in  = move[0] && in_valid;
   assign stage_ctrl.load_mul = move[1] && valid_ff[0];
   assign stage_ctrl.load_out = move[2] && valid_ff[1];

endmodule

// File: rtl/core/rtab_weight.sv
// Blend weight for one pixel: widened tint alpha times widened source alpha,
// or widened tint alpha squared in solid mode. Depends on rtab_pkg.
module rtab_weight (
   input  logic                            clock,
   input  rtab_pkg::stage_ctrl_type        stage_ctrl,
   input  rtab_pkg::cfg_type               cfg,
   input  logic [rtab_pkg::CHAN_W-1:0]     src_alpha,
   output logic [rtab_pkg::WEIGHT_W-1:0]   weight
);

   logic [rtab_pkg::WIDE_W-1:0]     wide_tint;
   logic [rtab_pkg::WIDE_W-1:0]     wide_other;
   logic [2*rtab_pkg::WIDE_W-1:0]   prod;
   logic [rtab_pkg::WEIGHT_W-1:0]   weight_ff;

   always_comb begin
      wide_tint  = rtab_pkg::widen(cfg.tint_alpha);
      wide_other = (cfg.blend_mode == rtab_pkg::MODE_SOLID) ? wide_tint
                                                           : rtab_pkg::widen(src_alpha);
      prod       = wide_tint * wide_other;
   end

   // product never exceeds 65536
   always_ff @(posedge clock) begin
      if (stage_ctrl.load_in) begin
         weight_ff <= prod[rtab_pkg::WEIGHT_W-1:0];
      end
   end

   assign weight = weight_ff;

endmodule

// File: rtl/core/rtab_lane.sv
// One channel lane: target (scaled source or solid color), signed move toward
// the target by weight >> 16, and 8-bit wrapping sum. Depends on rtab_pkg.
module rtab_lane (
   input  logic                          clock,
   input  rtab_pkg::stage_ctrl_type      stage_ctrl,
   input  rtab_pkg::blend_mode_type      blend_mode,
   input  logic [rtab_pkg::CHAN_W-1:0]   tint,
   input  logic [rtab_pkg::CHAN_W-1:0]   src,
   input  logic [rtab_pkg::CHAN_W-1:0]   dst,
   input  logic [rtab_pkg::WEIGHT_W-1:0] weight,
   output logic [rtab_pkg::CHAN_W-1:0]   result
);

   logic [rtab_pkg::SCALE_W-1:0]        scaled;
   logic [rtab_pkg::CHAN_W-1:0]         target_in;
   logic [rtab_pkg::CHAN_W-1:0]         target_ff;
   logic [rtab_pkg::CHAN_W-1:0]         dst_s1_ff;
   logic signed [rtab_pkg::DIFF_W-1:0]  diff;
   logic signed [rtab_pkg::WEIGHT_W:0]  weight_s;
   logic signed [rtab_pkg::PROD_W-1:0]  prod;
   logic [rtab_pkg::CHAN_W-1:0]         delta_ff;
   logic [rtab_pkg::CHAN_W-1:0]         dst_s2_ff;
   logic [rtab_pkg::CHAN_W-1:0]         result_ff;

   // stage 1: target
   always_comb begin
      scaled    = rtab_pkg::widen(tint) * src;
      target_in = (blend_mode == rtab_pkg::MODE_SOLID)
                  ? tint : scaled[rtab_pkg::CHAN_W +: rtab_pkg::CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load_in) begin
         target_ff <= target_in;
         dst_s1_ff <= dst;
      end
   end

   // stage 2: (target - dst) * weight, arithmetic shift, low byte kept
   always_comb begin
      diff     = signed'({2'b00, target_ff}) - signed'({2'b00, dst_s1_ff});
      weight_s = signed'({1'b0, weight});
      prod     = diff * weight_s;
   end

   always_ff @(posedge clock) begin
      if (stage_ctrl.load_mul) begin
         delta_ff  <= prod[rtab_pkg::WEIGHT_SHIFT +: rtab_pkg::CHAN_W];
         dst_s2_ff <= dst_s1_ff;
      end
   end

   // stage 3: wrapping add
   always_ff @(posedge clock) begin
      if (stage_ctrl.load_out) begin
         result_ff <= dst_s2_ff + delta_ff;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/core/rgba_tint_alpha_blend_unit.sv
// Top level of the RGBA tint / alpha blend unit: register port, pipeline
// control, weight unit and four channel lanes merged into one response word.
// Depends on rtab_pkg, rtab_if, rtab_csr, rtab_ctrl, rtab_weight, rtab_lane.
//
//   port     dir  word
//   req_bus  in   source RGBA8 + destination RGBA8 pixel
//   rsp_bus  out  blended RGBA8 pixel
//   csr_bus  in   register index (3 bits) + write data (8 bits)
//
// Three stages: weight and target, multiply, add into the output register.
// One word per clock; each stage refills as it drains, so a stalled response only
// holds the words behind it once the stages fill. Reset clears the stage valids
// and loads tint 255/255/255/255, tint mode. The register port is always ready;
// the user writes only while no word is in flight; the block does not enforce it.
module rgba_tint_alpha_blend_unit (
   input  logic        clock,
   input  logic        reset,
   rtab_req_if.sink    req_bus,
   rtab_rsp_if.source  rsp_bus,
   rtab_csr_if.sink    csr_bus
);

   rtab_pkg::cfg_type        cfg;
   rtab_pkg::stage_ctrl_type stage_ctrl;
   logic [rtab_pkg::WEIGHT_W-1:0] weight;
   logic [rtab_pkg::CHAN_W-1:0]   lane_tint [rtab_pkg::NUM_LANES];
   logic [rtab_pkg::CHAN_W-1:0]   lane_src  [rtab_pkg::NUM_LANES];
   logic [rtab_pkg::CHAN_W-1:0]   lane_dst  [rtab_pkg::NUM_LANES];
   logic [rtab_pkg::CHAN_W-1:0]   lane_out  [rtab_pkg::NUM_LANES];

   rtab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rtab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .stage_ctrl (stage_ctrl)
   );

   rtab_weight u_weight (
      .clock      (clock),
      .stage_ctrl (stage_ctrl),
      .cfg        (cfg),
      .src_alpha  (req_bus.src_alpha),
      .weight     (weight)
   );

   // Alpha lane: a tint of 255 widens to 256 and passes the source alpha
   // through unscaled; in solid mode the tint alpha is the target.
   always_comb begin
      lane_tint[0] = cfg.tint_red;
      lane_tint[1] = cfg.tint_green;
      lane_tint[2] = cfg.tint_blue;
      lane_tint[3] = (cfg.blend_mode == rtab_pkg::MODE_SOLID)
                     ? cfg.tint_alpha : rtab_pkg::CHAN_MAX;
      lane_src[0]  = req_bus.src_red;
      lane_src[1]  = req_bus.src_green;
      lane_src[2]  = req_bus.src_blue;
      lane_src[3]  = req_bus.src_alpha;
      lane_dst[0]  = req_bus.dst_red;
      lane_dst[1]  = req_bus.dst_green;
      lane_dst[2]  = req_bus.dst_blue;
      lane_dst[3]  = req_bus.dst_alpha;
   end

   for (genvar g = 0; g < rtab_pkg::NUM_LANES; g++) begin : g_lane
      rtab_lane u_lane (
         .clock      (clock),
         .stage_ctrl (stage_ctrl),
         .blend_mode (cfg.blend_mode),
         .tint       (lane_tint[g]),
         .src        (lane_src[g]),
         .dst        (lane_dst[g]),
         .weight     (weight),
         .result     (lane_out[g])
      );
   end

   assign rsp_bus.out_red   = lane_out[0];
   assign rsp_bus.out_green = lane_out[1];
   assign rsp_bus.out_blue  = lane_out[2];
   assign rsp_bus.out_alpha = lane_out[3];

endmodule

// File: tb/tb_rgba_tint_alpha_blend_unit.sv
// Testbench for rgba_tint_alpha_blend_unit: drives pixel pairs and register writes,
// predicts each blended pixel in a scoreboard class and checks the responses in order.
// Depends on rtab_pkg, rtab_if and the unit itself.
`timescale 1ns / 1ps

module tb_rgba_tint_alpha_blend_unit;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_CSR_IDX    = 1 << rtab_pkg::CSR_IDX_W;

   typedef struct packed {
      logic [rtab_pkg::CHAN_W-1:0] src_red;
      logic [rtab_pkg::CHAN_W-1:0] src_green;
      logic [rtab_pkg::CHAN_W-1:0] src_blue;
      logic [rtab_pkg::CHAN_W-1:0] src_alpha;
      logic [rtab_pkg::CHAN_W-1:0] dst_red;
      logic [rtab_pkg::CHAN_W-1:0] dst_green;
      logic [rtab_pkg::CHAN_W-1:0] dst_blue;
      logic [rtab_pkg::CHAN_W-1:0] dst_alpha;
   } pixel_pair_type;

   typedef struct packed {
      logic [rtab_pkg::CHAN_W-1:0] red;
      logic [rtab_pkg::CHAN_W-1:0] green;
      logic [rtab_pkg::CHAN_W-1:0] blue;
      logic [rtab_pkg::CHAN_W-1:0] alpha;
   } rgba_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_plan_type;

   class blend_scoreboard;
      logic [rtab_pkg::CHAN_W-1:0] tint_red, tint_green, tint_blue, tint_alpha;
      rtab_pkg::blend_mode_type    mode;
      rgba_type          blended_q[$];
      int                errors;
      string             lane_name[4] = '{"red", "green", "blue", "alpha"};

      function new();
         tint_red   = '1;
         tint_green = '1;
         tint_blue  = '1;
         tint_alpha = '1;
         mode       = rtab_pkg::MODE_TINT;
         errors     = 0;
      endfunction

      function void set_reg(logic [rtab_pkg::CSR_IDX_W-1:0] idx,
                            logic [rtab_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rtab_pkg::CSR_TINT_RED:   tint_red   = data;
            rtab_pkg::CSR_TINT_GREEN: tint_green = data;
            rtab_pkg::CSR_TINT_BLUE:  tint_blue  = data;
            rtab_pkg::CSR_TINT_ALPHA: tint_alpha = data;
            rtab_pkg::CSR_BLEND_MODE: mode       = rtab_pkg::blend_mode_type'(data[0]);
            default: ;
         endcase
      endfunction

      // 0 stays 0, anything else gains one, so 255 maps to a full 256
      function logic [rtab_pkg::WIDE_W-1:0] grow(logic [rtab_pkg::CHAN_W-1:0] v);
         return (v == '0) ? '0 : {1'b0, v} + 1'b1;
      endfunction

      // dst + floor((target - dst) * weight / 2^16), kept to 8 bits
      function logic [rtab_pkg::CHAN_W-1:0] move_toward(
            logic [rtab_pkg::CHAN_W-1:0]   target,
            logic [rtab_pkg::CHAN_W-1:0]   dst,
            logic [rtab_pkg::WEIGHT_W-1:0] weight);
         logic signed [31:0] diff;
         logic signed [31:0] prod;
         diff = $signed({24'd0, target}) - $signed({24'd0, dst});
         prod = diff * $signed({15'd0, weight});
         return dst + prod[rtab_pkg::WEIGHT_SHIFT +: rtab_pkg::CHAN_W];
      endfunction

      function logic [rtab_pkg::CHAN_W-1:0] tinted(logic [rtab_pkg::CHAN_W-1:0] tint,
                                                   logic [rtab_pkg::CHAN_W-1:0] src);
         logic [rtab_pkg::SCALE_W-1:0] scaled;
         scaled = grow(tint) * src;
         return scaled[rtab_pkg::CHAN_W +: rtab_pkg::CHAN_W];
      endfunction

      function rgba_type blend_pixel(pixel_pair_type p);
         rgba_type                      goal;
         rgba_type                      res;
         logic [rtab_pkg::WEIGHT_W-1:0] weight;
         if (mode == rtab_pkg::MODE_SOLID) begin
            goal   = {tint_red, tint_green, tint_blue, tint_alpha};
            weight = grow(tint_alpha) * grow(tint_alpha);
         end else begin
            goal   = {tinted(tint_red, p.src_red), tinted(tint_green, p.src_green),
                      tinted(tint_blue, p.src_blue), p.src_alpha};
            weight = grow(tint_alpha) * grow(p.src_alpha);
         end
         res.red   = move_toward(goal.red,   p.dst_red,   weight);
         res.green = move_toward(goal.green, p.dst_green, weight);
         res.blue  = move_toward(goal.blue,  p.dst_blue,  weight);
         res.alpha = move_toward(goal.alpha, p.dst_alpha, weight);
         return res;
      endfunction

      function void note_pixel(pixel_pair_type p);
         blended_q.push_back(blend_pixel(p));
      endfunction

      function void check_pixel(rgba_type got);
         rgba_type want;
         if (blended_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            return;
         end
         want = blended_q.pop_front();
         for (int k = 0; k < rtab_pkg::NUM_LANES; k++) begin
            if (want[8*(3-k) +: 8] !== got[8*(3-k) +: 8]) begin
               errors++;
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, lane_name[k],
                        want[8*(3-k) +: 8], got[8*(3-k) +: 8]);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   quiet_cycles;
   blend_scoreboard board;

   rtab_req_if req_bus ();
   rtab_rsp_if rsp_bus ();
   rtab_csr_if csr_bus ();

   rgba_tint_alpha_blend_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // receiver backpressure, redrawn every cycle
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // sample all three ports at the rising edge; also the stall watchdog
   always @(posedge clock) begin
      logic moved;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            board.note_pixel({req_bus.src_red, req_bus.src_green, req_bus.src_blue,
                              req_bus.src_alpha, req_bus.dst_red, req_bus.dst_green,
                              req_bus.dst_blue, req_bus.dst_alpha});
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_pixel({rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                               rsp_bus.out_alpha});
            moved = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            board.set_reg(csr_bus.index, csr_bus.data);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [rtab_pkg::CHAN_W-1:0] pick_level();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return 8'd1;
         default: return rtab_pkg::CHAN_W'($urandom);
      endcase
   endfunction

   function automatic pixel_pair_type random_pixel();
      pixel_pair_type p;
      p = {$urandom, $urandom};
      if ($urandom_range(3) == 0) p.src_alpha = pick_level();
      if ($urandom_range(7) == 0) p.dst_alpha = pick_level();
      if ($urandom_range(7) == 0) p.src_red   = pick_level();
      return p;
   endfunction

   task automatic set_idling(idle_plan_type plan);
      case (plan)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
         default:       begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
   endtask

   // entered and left at a falling edge; valid stays high across back-to-back words
   task automatic push_pixel(pixel_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.src_red   <= p.src_red;
      req_bus.src_green <= p.src_green;
      req_bus.src_blue  <= p.src_blue;
      req_bus.src_alpha <= p.src_alpha;
      req_bus.dst_red   <= p.dst_red;
      req_bus.dst_green <= p.dst_green;
      req_bus.dst_blue  <= p.dst_blue;
      req_bus.dst_alpha <= p.dst_alpha;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // stop sending and let every blended pixel come back
   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      while (board.blended_q.size() != 0) @(negedge clock);
      repeat (rtab_pkg::NUM_STAGES + 2) @(negedge clock);
   endtask

   task automatic write_reg(logic [rtab_pkg::CSR_IDX_W-1:0] idx,
                            logic [rtab_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_tints(logic [rtab_pkg::CHAN_W-1:0] r, logic [rtab_pkg::CHAN_W-1:0] g,
                              logic [rtab_pkg::CHAN_W-1:0] b, logic [rtab_pkg::CHAN_W-1:0] a,
                              logic [rtab_pkg::CSR_DATA_W-1:0] mode_word);
      write_reg(rtab_pkg::CSR_TINT_RED, r);
      write_reg(rtab_pkg::CSR_TINT_GREEN, g);
      write_reg(rtab_pkg::CSR_TINT_BLUE, b);
      write_reg(rtab_pkg::CSR_TINT_ALPHA, a);
      write_reg(rtab_pkg::CSR_BLEND_MODE, mode_word);
   endtask

   // random words split over the four idling plans, then drained
   task automatic run_random(int count);
      for (int q = 0; q < 4; q++) begin
         set_idling(idle_plan_type'(q));
         for (int i = 0; i < count / 4; i++) begin
            if ($urandom_range(149) == 0) drain_pixels();
            push_pixel(random_pixel());
         end
      end
      drain_pixels();
   endtask

   initial begin
      board             = new();
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.src_red   = '0;
      req_bus.src_green = '0;
      req_bus.src_blue  = '0;
      req_bus.src_alpha = '0;
      req_bus.dst_red   = '0;
      req_bus.dst_green = '0;
      req_bus.dst_blue  = '0;
      req_bus.dst_alpha = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset tint, tinted mode; words are {src rgba, dst rgba}
      set_idling(IDLE_NONE);
      push_pixel({32'h0000_0000, 32'h0000_0000});
      push_pixel({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      push_pixel({32'hFFFF_FFFF, 32'h0000_0000});   // full weight lands on target
      push_pixel({32'h0000_0000, 32'hFFFF_FFFF});   // zero alpha keeps dst
      push_pixel({32'h0000_00FF, 32'hFFFF_FFFF});   // full move down to 0
      push_pixel({32'hAAAA_AAAA, 32'h5555_5555});
      push_pixel({32'h5555_5555, 32'hAAAA_AAAA});
      push_pixel({32'h8040_2001, 32'h1020_4080});   // smallest nonzero alpha
      push_pixel({32'h7F80_81FE, 32'h0102_0304});
      push_pixel({32'hFFFF_FF80, 32'h0000_0000});
      push_pixel({32'h0000_0080, 32'hFFFF_FFFF});   // negative step, floor rounding
      push_pixel({32'h0180_FE80, 32'hFE7F_0201});
      push_pixel({32'h1234_5600, 32'h9ABC_DEF0});
      push_pixel({32'h0102_80FF, 32'h01FE_7F00});
      for (int i = 0; i < 6; i++) push_pixel(random_pixel());
      drain_pixels();
      run_random(200);

      // zero tint: no weight at all
      write_tints(8'd0, 8'd0, 8'd0, 8'd0, rtab_pkg::CSR_DATA_W'(rtab_pkg::MODE_TINT));
      run_random(100);

      // solid color, full alpha; upper data bits ignored
      write_tints(8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF);
      run_random(152);

      // solid color with zero alpha leaves dst alone
      write_tints(8'h01, 8'hFE, 8'h7F, 8'h00, 8'h03);
      run_random(100);

      // spare indexes must not disturb anything; mode word with bit 0 clear
      write_tints(8'h01, 8'hFE, 8'h80, 8'h01, 8'hFE);
      for (int i = int'(rtab_pkg::CSR_BLEND_MODE) + 1; i < NUM_CSR_IDX; i++) begin
         write_reg(rtab_pkg::CSR_IDX_W'(i), rtab_pkg::CSR_DATA_W'($urandom));
      end
      run_random(152);

      for (int n = 0; n < 5; n++) begin
         write_tints(pick_level(), pick_level(), pick_level(), pick_level(),
                     rtab_pkg::CSR_DATA_W'($urandom));
         run_random(152);
      end

      if (board.blended_q.size() != 0) begin
         $display("%0t: %0d pixels never returned", $time, board.blended_q.size());
      end
      if (board.errors == 0 && board.blended_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/rtab_pkg.sv
rtl/core/rtab_if.sv
rtl/core/rtab_csr.sv
rtl/core/rtab_ctrl.sv
rtl/core/rtab_weight.sv
rtl/core/rtab_lane.sv
rtl/core/rgba_tint_alpha_blend_unit.sv
tb/tb_rgba_tint_alpha_blend_unit.sv
